/* rtl/efr_pkg.sv */
package efr_pkg;

    // Default frame buffer size in bytes
    localparam int BUFFER_BYTES_DEF = 64;

    // Depth of the token queue between classifier and frame engine (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Escaped bytes are XORed with this mask
    localparam logic [7:0] ESC_XOR = 8'h20;

    // Start, length and three check bytes are overhead to the length field
    localparam int LEN_OVERHEAD = 5;

    // Register reset values
    localparam logic [7:0]  START_BYTE_RST     = 8'h7E;
    localparam logic [7:0]  ESCAPE_BYTE_RST    = 8'h7D;
    localparam logic [7:0]  STATUS_BYTE_RST    = 8'h7C;
    localparam logic [23:0] EXPECTED_CHECK_RST = 24'hFFFFFF;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_START_BYTE     = 2'd0;
    localparam logic [1:0] REG_ESCAPE_BYTE    = 2'd1;
    localparam logic [1:0] REG_STATUS_BYTE    = 2'd2;
    localparam logic [1:0] REG_EXPECTED_CHECK = 2'd3;

    // Error mask bit positions
    localparam int ERR_START    = 0;
    localparam int ERR_CHECK    = 1;
    localparam int ERR_LENGTH   = 2;
    localparam int ERR_ENDESC   = 3;
    localparam int ERR_BADESC   = 4;
    localparam int ERR_OVERFLOW = 5;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_START  = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_ESC    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_RECV = 3'b010,
        MODE_ESC  = 3'b100
    } t_mode;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  status_byte;
        logic [23:0] expected_check;
    } t_cfg;

    // One classified byte
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       esc_ok;        // data ^ ESC_XOR is a special byte
        logic       esc_is_start;  // data ^ ESC_XOR is the start byte
    } t_token;

    typedef struct packed {
        logic       frame_ok;
        logic [5:0] error_mask;
        logic [7:0] message_type;
        logic [7:0] first_param;
        logic [6:0] stored_count;
    } t_result;

endpackage

/* rtl/efr_classify.sv */
module efr_classify (
    input  logic [7:0]    i_rx_byte,
    input  efr_pkg::t_cfg i_cfg,
    output efr_pkg::t_token o_tok
);

    logic [7:0] unesc;

    assign unesc = i_rx_byte ^ efr_pkg::ESC_XOR;

    // Start wins over status, status over escape
    always_comb begin
        o_tok.data = i_rx_byte;
        o_tok.esc_is_start = (unesc == i_cfg.start_byte);
        o_tok.esc_ok = (unesc == i_cfg.start_byte) || (unesc == i_cfg.status_byte)
                       || (unesc == i_cfg.escape_byte);
        priority if (i_rx_byte == i_cfg.start_byte) begin
            o_tok.kind = efr_pkg::KIND_START;
        end else if (i_rx_byte == i_cfg.status_byte) begin
            o_tok.kind = efr_pkg::KIND_STATUS;
        end else if (i_rx_byte == i_cfg.escape_byte) begin
            o_tok.kind = efr_pkg::KIND_ESC;
        end else begin
            o_tok.kind = efr_pkg::KIND_DATA;
        end
    end

endmodule

/* rtl/efr_queue.sv */
module efr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  efr_pkg::t_token   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output efr_pkg::t_token   o_data
);

    localparam int QW = (efr_pkg::QUEUE_DEPTH > 1) ? $clog2(efr_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(efr_pkg::QUEUE_DEPTH + 1);

    efr_pkg::t_token r_slot [efr_pkg::QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(efr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/efr_frame.sv */
module efr_frame #(
    parameter int BUFFER_BYTES = efr_pkg::BUFFER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efr_pkg::t_cfg     i_cfg,
    input  logic              i_tok_valid,
    input  efr_pkg::t_token   i_tok,
    output logic              o_tok_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output efr_pkg::t_result  o_res
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);

    efr_pkg::t_mode   r_mode, n_mode;
    logic [CW-1:0]    r_count, n_count;
    logic [5:0]       r_err, n_err;
    logic [7:0]       r_b0, r_b1, r_b2, r_b3;
    logic [7:0]       n_b0, n_b1, n_b2, n_b3;
    logic [2:0][7:0]  r_tail, n_tail;   // [0] is the most recently stored byte
    logic             r_res_valid;
    efr_pkg::t_result r_res, n_res;

    logic             closing, consume;
    logic             do_append, app_is_start;
    logic [7:0]       app_byte;
    logic [5:0]       err_all;
    logic [23:0]      check;
    logic [7:0]       first_stored;

    assign closing   = (i_tok.kind == efr_pkg::KIND_START) && (r_mode != efr_pkg::MODE_IDLE);
    // A closing token waits while the result register is still occupied
    assign consume   = i_tok_valid && (!closing || !r_res_valid || i_pop);
    assign o_tok_pop = consume;
    assign o_empty   = !r_res_valid;
    assign o_res     = r_res;

    always_comb begin
        n_mode       = r_mode;
        n_count      = r_count;
        n_err        = r_err;
        n_b0         = r_b0;
        n_b1         = r_b1;
        n_b2         = r_b2;
        n_b3         = r_b3;
        n_tail       = r_tail;
        do_append    = 1'b0;
        app_is_start = 1'b0;
        app_byte     = i_tok.data;
        if (consume) begin
            unique case (i_tok.kind)
                efr_pkg::KIND_START: begin
                    if (r_mode == efr_pkg::MODE_IDLE) begin
                        n_mode       = efr_pkg::MODE_RECV;
                        do_append    = 1'b1;
                        app_is_start = 1'b1;
                    end else begin
                        n_mode  = efr_pkg::MODE_IDLE;
                        n_count = '0;
                        n_err   = '0;
                    end
                end
                efr_pkg::KIND_STATUS: begin
                    n_mode  = efr_pkg::MODE_IDLE;
                    n_count = '0;
                    n_err   = '0;
                end
                efr_pkg::KIND_ESC: begin
                    n_mode = efr_pkg::MODE_ESC;
                end
                efr_pkg::KIND_DATA: begin
                    n_mode = (r_count != '0) ? efr_pkg::MODE_RECV : efr_pkg::MODE_IDLE;
                    if (r_mode == efr_pkg::MODE_ESC) begin
                        if (i_tok.esc_ok) begin
                            do_append    = 1'b1;
                            app_byte     = i_tok.data ^ efr_pkg::ESC_XOR;
                            app_is_start = i_tok.esc_is_start;
                        end else begin
                            n_err[efr_pkg::ERR_BADESC] = 1'b1;
                        end
                    end else begin
                        do_append = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // Drop bytes before a start; flag overflow once the buffer is full
        if (do_append && (r_count != '0 || app_is_start)) begin
            if (r_count >= CW'(BUFFER_BYTES)) begin
                n_err[efr_pkg::ERR_OVERFLOW] = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                n_tail  = {r_tail[1], r_tail[0], app_byte};
                if (r_count == CW'(0)) n_b0 = app_byte;
                if (r_count == CW'(1)) n_b1 = app_byte;
                if (r_count == CW'(2)) n_b2 = app_byte;
                if (r_count == CW'(3)) n_b3 = app_byte;
            end
        end
    end

    // Evaluate the frame on the closing byte; unwritten positions read as zero
    always_comb begin
        first_stored = (r_count > CW'(0)) ? r_b0 : 8'd0;
        check = {(r_count >= CW'(3)) ? r_tail[2] : 8'd0,
                 (r_count >= CW'(2)) ? r_tail[1] : 8'd0,
                 (r_count >= CW'(1)) ? r_tail[0] : 8'd0};
        err_all = r_err;
        if (r_mode == efr_pkg::MODE_ESC) err_all[efr_pkg::ERR_ENDESC] = 1'b1;
        if (first_stored != i_cfg.start_byte) err_all[efr_pkg::ERR_START] = 1'b1;
        if (check != i_cfg.expected_check) err_all[efr_pkg::ERR_CHECK] = 1'b1;
        if (r_count < CW'(efr_pkg::LEN_OVERHEAD)
            || r_b1 != (8'(r_count) - 8'(efr_pkg::LEN_OVERHEAD))) begin
            err_all[efr_pkg::ERR_LENGTH] = 1'b1;
        end
        n_res.frame_ok     = (err_all == 6'd0);
        n_res.error_mask   = err_all;
        n_res.message_type = (r_count > CW'(2)) ? r_b2 : 8'd0;
        n_res.first_param  = (r_count > CW'(3)) ? r_b3 : 8'd0;
        n_res.stored_count = 7'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= efr_pkg::MODE_IDLE;
            r_count     <= '0;
            r_err       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_err   <= n_err;
            if (consume && closing) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0   <= n_b0;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
        r_b3   <= n_b3;
        r_tail <= n_tail;
        if (consume && closing) begin
            r_res <= n_res;
        end
    end

    a_hold_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok_valid && closing && r_res_valid && !i_pop) |-> !o_tok_pop)
        else $error("closing token consumed while result register is occupied");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_BYTES))
        else $error("byte count beyond buffer size");

    a_ok_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_res.frame_ok == (r_res.error_mask == 6'd0)))
        else $error("frame_ok disagrees with error mask");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && closing) |=> (r_mode == efr_pkg::MODE_IDLE && r_count == '0
                                    && r_err == '0 && r_res_valid))
        else $error("frame state not cleared after close");

endmodule

/* rtl/escaped_frame_receiver_unit.sv */
// Escaped frame receiver: byte-stuffed deframer for a serial receive stream.
// Input channel: push one received byte on i_rx_byte; the transaction is taken
// at a rising edge with push high and full low. A classifier tags each byte
// (start, status, escape or data) and hands it to a two-entry token queue; the
// frame engine behind the queue undoes escaping, stores the frame and judges
// it when the closing start byte arrives.
// Result channel: while empty is low, the frame verdict sits on o_frame_ok,
// o_error_mask, o_message_type, o_first_param and o_stored_count; pop takes it.
// Throughput: one byte per cycle while full stays low (see Stall below).
// Result path: the edge that accepts a closing byte writes it into the queue; a
// later edge moves it through the engine into the result register, once it is
// at the queue head and the result register is free or being popped.
// Stall: a result that is not popped holds the next closing byte in the queue;
// bytes keep flowing until the queue fills, then full rises.
// Reset (synchronous, i_rst_n low): registers return to 0x7E/0x7D/0x7C/0xFFFFFF,
// queue and result register empty, receiver idle with no stored bytes.
// Configuration: APB-style, registers at byte addresses 0, 4, 8 and 12; write
// only while no transaction is in flight.
module escaped_frame_receiver_unit #(
    parameter int BUFFER_BYTES = efr_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        empty,
    input  logic        pop,
    output logic        o_frame_ok,
    output logic [5:0]  o_error_mask,
    output logic [7:0]  o_message_type,
    output logic [7:0]  o_first_param,
    output logic [6:0]  o_stored_count,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    efr_pkg::t_cfg    r_cfg;
    efr_pkg::t_token  front_tok, back_tok;
    efr_pkg::t_result res;
    logic             q_valid, q_pop;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register file: written in the access phase of a write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte     <= efr_pkg::START_BYTE_RST;
            r_cfg.escape_byte    <= efr_pkg::ESCAPE_BYTE_RST;
            r_cfg.status_byte    <= efr_pkg::STATUS_BYTE_RST;
            r_cfg.expected_check <= efr_pkg::EXPECTED_CHECK_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                efr_pkg::REG_START_BYTE:     r_cfg.start_byte     <= pwdata[7:0];
                efr_pkg::REG_ESCAPE_BYTE:    r_cfg.escape_byte    <= pwdata[7:0];
                efr_pkg::REG_STATUS_BYTE:    r_cfg.status_byte    <= pwdata[7:0];
                efr_pkg::REG_EXPECTED_CHECK: r_cfg.expected_check <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb begin
        unique case (reg_idx)
            efr_pkg::REG_START_BYTE:     prdata = {24'd0, r_cfg.start_byte};
            efr_pkg::REG_ESCAPE_BYTE:    prdata = {24'd0, r_cfg.escape_byte};
            efr_pkg::REG_STATUS_BYTE:    prdata = {24'd0, r_cfg.status_byte};
            efr_pkg::REG_EXPECTED_CHECK: prdata = {8'd0, r_cfg.expected_check};
            default:                     prdata = 32'd0;
        endcase
    end

    // Front: tag each incoming byte
    efr_classify u_classify (
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_tok     (front_tok)
    );

    // Decouple the classifier from the frame engine
    efr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_tok),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (back_tok)
    );

    // Back: frame state, storage, verdict and result register
    efr_frame #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_tok_valid (q_valid),
        .i_tok       (back_tok),
        .o_tok_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_frame_ok     = res.frame_ok;
    assign o_error_mask   = res.error_mask;
    assign o_message_type = res.message_type;
    assign o_first_param  = res.first_param;
    assign o_stored_count = res.stored_count;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    // Error mask values built from the package bit positions
    localparam logic [5:0] E_START    = 6'(1 << efr_pkg::ERR_START);
    localparam logic [5:0] E_CHECK    = 6'(1 << efr_pkg::ERR_CHECK);
    localparam logic [5:0] E_LENGTH   = 6'(1 << efr_pkg::ERR_LENGTH);
    localparam logic [5:0] E_ENDESC   = 6'(1 << efr_pkg::ERR_ENDESC);
    localparam logic [5:0] E_BADESC   = 6'(1 << efr_pkg::ERR_BADESC);
    localparam logic [5:0] E_OVERFLOW = 6'(1 << efr_pkg::ERR_OVERFLOW);

    // Reset values of the special bytes
    localparam logic [7:0] S_RST = efr_pkg::START_BYTE_RST;
    localparam logic [7:0] X_RST = efr_pkg::ESCAPE_BYTE_RST;
    localparam logic [7:0] A_RST = efr_pkg::STATUS_BYTE_RST;
    localparam logic [7:0] S_ESC = efr_pkg::START_BYTE_RST ^ efr_pkg::ESC_XOR;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 180;
    // Closing byte moves from the queue through the engine into the result register
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT  = 4000;

    localparam efr_pkg::t_result NO_VERDICT = '0;

    // Ways a generated frame can be damaged on purpose
    typedef enum int {
        FAULT_NONE,
        FAULT_LENGTH,
        FAULT_CHECK,
        FAULT_TRUNCATE,
        FAULT_OPEN_ESCAPE,
        FAULT_BAD_ESCAPE,
        FAULT_ABORT
    } t_fault;

    // One row of the directed sequence; verdict is used only when typed is set
    typedef struct {
        logic [7:0] data;
        int unsigned reps;
        bit typed;
        efr_pkg::t_result verdict;
    } t_row;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        empty;
    logic        pop       = 1'b0;
    logic        o_frame_ok;
    logic [5:0]  o_error_mask;
    logic [7:0]  o_message_type;
    logic [7:0]  o_first_param;
    logic [6:0]  o_stored_count;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = 4'h0;
    logic [31:0] pwdata    = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    escaped_frame_receiver_unit DUT (.*);

    // Free-running clock, 2 ns period
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Deframer shadow: register copy and receiver state
    // ------------------------------------------------------------------
    efr_pkg::t_cfg    cfg;
    efr_pkg::t_mode   link_mode;
    int unsigned      held_count;
    logic [7:0]       held_bytes [efr_pkg::BUFFER_BYTES_DEF];
    logic [5:0]       sticky_errs;

    efr_pkg::t_result pending_verdicts [$];
    logic [7:0]       wire_q [$];

    int               fails          = 0;
    int unsigned      bytes_sent     = 0;
    int unsigned      frames_checked = 0;
    int unsigned      frames_clean   = 0;
    int unsigned      config_sets    = 0;
    int unsigned      gap_odds       = 0;
    int unsigned      stall_odds     = 0;
    int unsigned      pop_hold       = 0;
    int unsigned      idle_cycles    = 0;
    efr_pkg::t_result head_verdict;

    // Directed walk under reset registers: idle-side errors, empty close,
    // escaped specials, abort, escaped start at count zero, overflow
    t_row directed [24] = '{
        '{8'h55, 1, 1'b0, NO_VERDICT},                      // dropped before any start
        '{X_RST, 1, 1'b0, NO_VERDICT},
        '{8'h00, 1, 1'b0, NO_VERDICT},                      // bad escape while idle
        '{S_RST, 1, 1'b0, NO_VERDICT},
        '{S_RST, 1, 1'b1,
          '{1'b0, E_BADESC | E_CHECK | E_LENGTH, 8'h00, 8'h00, 7'd1}},
        '{X_RST, 1, 1'b0, NO_VERDICT},
        '{S_RST, 1, 1'b1,                                   // close with nothing stored
          '{1'b0, E_START | E_CHECK | E_LENGTH | E_ENDESC, 8'h00, 8'h00, 7'd0}},
        '{S_RST, 1, 1'b0, NO_VERDICT},
        '{8'h02, 1, 1'b0, NO_VERDICT},
        '{X_RST, 1, 1'b0, NO_VERDICT},
        '{S_ESC, 1, 1'b0, NO_VERDICT},
        '{8'h00, 1, 1'b0, NO_VERDICT},
        '{8'hFF, 3, 1'b0, NO_VERDICT},
        '{S_RST, 1, 1'b1, '{1'b1, 6'h00, S_RST, 8'h00, 7'd7}},
        '{S_RST, 1, 1'b0, NO_VERDICT},
        '{A_RST, 1, 1'b0, NO_VERDICT},                      // silent abort
        '{X_RST, 1, 1'b0, NO_VERDICT},
        '{S_ESC, 1, 1'b0, NO_VERDICT},                      // stored, mode returns to idle
        '{S_RST, 1, 1'b0, NO_VERDICT},
        '{X_RST, 1, 1'b0, NO_VERDICT},
        '{S_RST, 1, 1'b1,                                   // ends inside an escape
          '{1'b0, E_ENDESC | E_CHECK | E_LENGTH, 8'h00, 8'h00, 7'd2}},
        '{S_RST, 1, 1'b0, NO_VERDICT},
        '{8'h00, 70, 1'b0, NO_VERDICT},                     // run past the buffer
        '{S_RST, 1, 1'b1,
          '{1'b0, E_OVERFLOW | E_CHECK | E_LENGTH, 8'h00, 8'h00, 7'd64}}
    };

    function automatic void reset_frame();
        link_mode   = efr_pkg::MODE_IDLE;
        held_count  = 0;
        sticky_errs = '0;
    endfunction

    // Positions not written in this frame read as zero
    function automatic logic [7:0] frame_byte(int unsigned pos);
        return (pos < held_count) ? held_bytes[pos] : 8'h00;
    endfunction

    function automatic logic [7:0] frame_byte_back(int unsigned back);
        return (back > held_count) ? 8'h00 : frame_byte(held_count - back);
    endfunction

    function automatic void store_byte(logic [7:0] c);
        if (held_count == 0 && c != cfg.start_byte)
            return;
        if (held_count >= efr_pkg::BUFFER_BYTES_DEF) begin
            sticky_errs[efr_pkg::ERR_OVERFLOW] = 1'b1;
            return;
        end
        held_bytes[held_count] = c;
        held_count++;
    endfunction

    // Advance the shadow by one byte; return 1 with the verdict on a close
    function automatic bit deframe(input logic [7:0] b, output efr_pkg::t_result res);
        logic [7:0]  c;
        logic [5:0]  err;
        logic [23:0] chk;
        bit          keep;
        res = '0;
        // Classification order: start, then status, then escape
        if (b == cfg.start_byte) begin
            if (link_mode == efr_pkg::MODE_IDLE) begin
                link_mode = efr_pkg::MODE_RECV;
                store_byte(b);
                return 1'b0;
            end
            if (link_mode == efr_pkg::MODE_ESC)
                sticky_errs[efr_pkg::ERR_ENDESC] = 1'b1;
            err = sticky_errs;
            chk = {frame_byte_back(3), frame_byte_back(2), frame_byte_back(1)};
            if (frame_byte(0) != cfg.start_byte)
                err[efr_pkg::ERR_START] = 1'b1;
            if (chk != cfg.expected_check)
                err[efr_pkg::ERR_CHECK] = 1'b1;
            if (held_count < efr_pkg::LEN_OVERHEAD ||
                int'(frame_byte(1)) != int'(held_count) - efr_pkg::LEN_OVERHEAD)
                err[efr_pkg::ERR_LENGTH] = 1'b1;
            res.frame_ok     = (err == '0);
            res.error_mask   = err;
            res.message_type = frame_byte(2);
            res.first_param  = frame_byte(3);
            res.stored_count = 7'(held_count);
            reset_frame();
            return 1'b1;
        end
        if (b == cfg.status_byte) begin
            reset_frame();
            return 1'b0;
        end
        if (b == cfg.escape_byte) begin
            link_mode = efr_pkg::MODE_ESC;
            return 1'b0;
        end
        c    = b;
        keep = 1'b1;
        if (link_mode == efr_pkg::MODE_ESC) begin
            c = b ^ efr_pkg::ESC_XOR;
            if (c != cfg.start_byte && c != cfg.status_byte && c != cfg.escape_byte) begin
                sticky_errs[efr_pkg::ERR_BADESC] = 1'b1;
                keep = 1'b0;
            end
        end
        // Mode follows the count before this byte is stored
        link_mode = (held_count > 0) ? efr_pkg::MODE_RECV : efr_pkg::MODE_IDLE;
        if (keep)
            store_byte(c);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hold the byte on the bus until full drops, then advance the shadow
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input efr_pkg::t_result verdict);
        efr_pkg::t_result got;
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full !== 1'b0);
        bytes_sent++;
        if (deframe(b, got))
            pending_verdicts.push_back(typed ? verdict : got);
    endtask

    task automatic maybe_gap();
        if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge i_clk);
        end
    endtask

    // Drop push and wait out every outstanding verdict
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // One APB transfer: setup, access, then an idle phase with psel low
    task automatic reg_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Optionally write all four registers, then read each one back
    task automatic sync_config(input efr_pkg::t_cfg c, input bit do_write);
        logic [31:0] rd;
        logic [31:0] vals [4];
        vals[efr_pkg::REG_START_BYTE]     = {24'h0, c.start_byte};
        vals[efr_pkg::REG_ESCAPE_BYTE]    = {24'h0, c.escape_byte};
        vals[efr_pkg::REG_STATUS_BYTE]    = {24'h0, c.status_byte};
        vals[efr_pkg::REG_EXPECTED_CHECK] = {8'h0, c.expected_check};
        if (do_write) begin
            for (int i = 0; i < 4; i++)
                reg_xfer(1'b1, 2'(i), vals[i], rd);
            config_sets++;
        end
        cfg = c;
        for (int i = 0; i < 4; i++) begin
            reg_xfer(1'b0, 2'(i), 32'h0, rd);
            if (rd !== vals[i]) begin
                $error("register %0d: expected 0x%0h, got 0x%0h", i, vals[i], rd);
                fails++;
            end
        end
    endtask

    // Escape any content byte that collides with a special byte
    task automatic put_escaped(input logic [7:0] v);
        if (v == cfg.start_byte || v == cfg.escape_byte || v == cfg.status_byte) begin
            wire_q.push_back(cfg.escape_byte);
            wire_q.push_back(v ^ efr_pkg::ESC_XOR);
        end else begin
            wire_q.push_back(v);
        end
    endtask

    // Raw line noise, biased toward the special bytes
    task automatic build_noise();
        int unsigned len;
        logic [7:0]  v;
        len = $urandom_range(10, 1);
        repeat (len) begin
            case ($urandom_range(7, 0))
                0: v = cfg.start_byte;
                1: v = cfg.escape_byte;
                2: v = cfg.status_byte;
                default: v = 8'($urandom);
            endcase
            wire_q.push_back(v);
        end
    endtask

    // Well-formed frame with random content; now and then damage one part
    task automatic build_frame();
        int unsigned n_params;
        int unsigned mark;
        int unsigned keep_check;
        t_fault      fault;
        logic [23:0] check;
        n_params   = ($urandom_range(11, 0) == 0) ? $urandom_range(72, 50)
                                                  : $urandom_range(6, 0);
        fault      = ($urandom_range(3, 0) == 0)
                   ? t_fault'($urandom_range(FAULT_ABORT, FAULT_LENGTH)) : FAULT_NONE;
        mark       = $urandom_range(n_params, 0);
        check      = (fault == FAULT_CHECK) ? 24'($urandom) : cfg.expected_check;
        keep_check = (fault == FAULT_TRUNCATE) ? $urandom_range(2, 0) : 3;
        if ($urandom_range(7, 0) == 0)
            build_noise();
        wire_q.push_back(cfg.start_byte);
        // Length counts type and parameters: stored bytes minus the overhead
        put_escaped((fault == FAULT_LENGTH) ? 8'($urandom) : 8'(n_params + 1));
        put_escaped(8'($urandom));
        for (int i = 0; i <= n_params; i++) begin
            if (i == mark && fault == FAULT_BAD_ESCAPE) begin
                wire_q.push_back(cfg.escape_byte);
                wire_q.push_back(8'($urandom));
            end
            if (i == mark && fault == FAULT_ABORT)
                wire_q.push_back(cfg.status_byte);
            if (i < n_params)
                put_escaped(8'($urandom));
        end
        for (int k = 0; k < keep_check; k++)
            put_escaped(check[23 - 8 * k -: 8]);
        if (fault == FAULT_OPEN_ESCAPE)
            wire_q.push_back(cfg.escape_byte);
        wire_q.push_back(cfg.start_byte);
    endtask

    function automatic int unsigned pick_odds();
        case ($urandom_range(2, 0))
            0: return 0;
            1: return 3;
            default: return 10;
        endcase
    endfunction

    // Register set per phase: equal specials, extremes, random, then reset values
    function automatic efr_pkg::t_cfg phase_config(int ph);
        efr_pkg::t_cfg c;
        c.start_byte     = 8'($urandom);
        c.escape_byte    = 8'($urandom);
        c.status_byte    = 8'($urandom);
        c.expected_check = 24'($urandom);
        if (ph == 0)
            c = '{8'h00, 8'h00, 8'h00, 24'h000000};
        else if (ph == 1)
            c = '{8'hFF, 8'h00, 8'hFF, 24'hFFFFFF};
        else if (ph == PHASES - 1)
            c = '{S_RST, X_RST, A_RST, efr_pkg::EXPECTED_CHECK_RST};
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random pop stalls and comparison with the oldest verdict
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict popped with none outstanding");
                fails++;
            end else begin
                head_verdict = pending_verdicts.pop_front();
                compare_field("frame_ok", head_verdict.frame_ok, o_frame_ok);
                compare_field("error_mask", head_verdict.error_mask, o_error_mask);
                compare_field("message_type", head_verdict.message_type, o_message_type);
                compare_field("first_param", head_verdict.first_param, o_first_param);
                compare_field("stored_count", head_verdict.stored_count, o_stored_count);
                frames_checked++;
                if (head_verdict.frame_ok)
                    frames_clean++;
            end
        end
        // Hold pop low for a random burst now and then
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
            pop <= 1'b0;
            pop_hold = $urandom_range(10, 0);
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: end the run if no transaction of any kind moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase_base;
        bit          paused;
        cfg = '{S_RST, X_RST, A_RST, efr_pkg::EXPECTED_CHECK_RST};
        reset_frame();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers must come out of reset at their defaults
        sync_config(cfg, 1'b0);

        // Directed walk with light idling on both sides
        gap_odds   = 4;
        stall_odds = 4;
        foreach (directed[r]) begin
            for (int k = 0; k < directed[r].reps; k++) begin
                send_byte(directed[r].data, directed[r].typed, directed[r].verdict);
                maybe_gap();
            end
        end

        // Random phases, each under its own register set
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            sync_config(phase_config(ph), 1'b1);
            phase_base = bytes_sent;
            paused     = 1'b0;
            while (bytes_sent - phase_base < ITEMS_PER_PHASE) begin
                // Last phase runs flat out with no idling on either side
                gap_odds   = (ph == PHASES - 1) ? 0 : pick_odds();
                stall_odds = (ph == PHASES - 1) ? 0 : pick_odds();
                if ($urandom_range(9, 0) < 7)
                    build_frame();
                else
                    build_noise();
                while (wire_q.size() != 0) begin
                    send_byte(wire_q.pop_front(), 1'b0, NO_VERDICT);
                    maybe_gap();
                end
                // Once mid-run, hold the sender until every verdict is back
                if (ph == 2 && !paused && bytes_sent - phase_base >= ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);

        $display("Run summary: %0d bytes pushed, %0d frame verdicts compared (%0d clean),",
                 bytes_sent, frames_checked, frames_clean);
        $display("%0d register sets including equal specials and extremes, stalls both sides",
                 config_sets);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
